// ===== rtl/rls_pkg.sv =====
// rls_pkg: payload types, register indexes and fixed-point helpers
// for the RLS ARX estimator. No dependencies.
package rls_pkg;

  localparam int PARAM_COUNT = 4;
  localparam int NUM_REGS    = 6;

  localparam logic [2:0] REG_LAMBDA  = 3'd0;
  localparam logic [2:0] REG_INITCOV = 3'd1;
  localparam logic [2:0] REG_INIT_A1 = 3'd2;
  localparam logic [2:0] REG_INIT_A2 = 3'd3;
  localparam logic [2:0] REG_INIT_B1 = 3'd4;
  localparam logic [2:0] REG_INIT_B2 = 3'd5;

  localparam logic [16:0] LAMBDA_RST  = 17'd64881;
  localparam logic [30:0] INITCOV_RST = 31'd65536000;

  typedef struct packed {
    logic signed [31:0] plant_input;
    logic signed [31:0] plant_output;
  } rls_in_t;

  typedef struct packed {
    logic signed [31:0] est_a1;
    logic signed [31:0] est_a2;
    logic signed [31:0] est_b1;
    logic signed [31:0] est_b2;
    logic signed [31:0] prediction_error;
  } rls_out_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [67:0] hi;
    logic signed [67:0] lo;
    hi = 68'sd2147483647;
    lo = -68'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

// ===== rtl/rls_mac.sv =====
// rls_mac: shared 32x32 multiplier with round-half-up scaling and a
// 68-bit accumulator. Depends on rls_pkg.
module rls_mac import rls_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               clr,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [67:0] acc
);

  logic signed [63:0] prod_r;
  logic               en_r;
  logic signed [67:0] acc_r;
  logic signed [63:0] rnd;

  // Rounded product, arithmetic shift floors
  assign rnd = (prod_r + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    en_r   <= en;
    if (clr) acc_r <= '0;
    else if (en_r) acc_r <= acc_r + 68'(rnd);
  end

  assign acc = acc_r;

endmodule

// ===== rtl/rls_div.sv =====
// rls_div: restoring signed divider, one quotient bit per cycle,
// quotient truncated toward zero. Depends on rls_pkg.
module rls_div import rls_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               done,
  output logic signed [63:0] quo
);

  logic [63:0] rem_r, rem_nxt, q_r, q_nxt, d_r;
  logic [6:0]  cnt_r;
  logic        neg_r, busy_r;
  logic [64:0] trial;

  assign trial = {rem_r, q_r[63]} - {1'b0, d_r};

  always_comb begin
    rem_nxt = {rem_r[62:0], q_r[63]};
    q_nxt   = {q_r[62:0], 1'b0};
    if (!trial[64]) begin
      rem_nxt = trial[63:0];
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd64;
        rem_r  <= '0;
        q_r    <= num[63] ? -num : num;
        d_r    <= den[63] ? -den : den;
        neg_r  <= num[63] ^ den[63];
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quo = neg_r ? -q_r : q_r;

endmodule

// ===== rtl/rls_arx_parameter_estimator_top.sv =====
// rls_arx_parameter_estimator_top: sequencer, state registers and config
// for a 4-parameter RLS estimator. Depends on rls_pkg, rls_mac, rls_div.
//
// Usage: present a sample {plant_input, plant_output} on in_data with
// in_valid; it is taken when in_stall is low. in_stall stays high while a
// transaction is being processed and while cfg_valid is high. One result
// transaction leaves on out_data/out_valid and is taken when out_stall is
// low; the next sample may be accepted while the result waits.
// A new sample is not taken until the current one has been processed. One
// shared multiplier forms sixty products, and a 64-step divider forms the
// four gains and sixteen covariance rescales, so the divider dominates. A
// zero denominator skips the gain divisions; a zero lambda skips the
// rescales.
// Reset, and any config write to a valid index, reload theta from the
// init registers, set P to initial_covariance on the diagonal and clear
// the histories. Config writes are taken when the block is idle and no
// result waits (cfg_ready high). A stalled result holds its data.
module rls_arx_parameter_estimator_top import rls_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  rls_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output rls_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0, S_MAC = 4'd1, S_MWAIT = 4'd2,
                         S_DIV = 4'd3, S_DWAIT = 4'd4, S_OUT = 4'd5;
  // Phases
  localparam logic [2:0] PH_E = 3'd0, PH_PPHI = 3'd1, PH_DEN = 3'd2,
                         PH_PHIP = 3'd3, PH_TH = 3'd4, PH_PUPD = 3'd5,
                         PH_GAIN = 3'd6;

  logic [3:0]  state_r;
  logic [2:0]  ph_r;
  logic [1:0]  i_r, j_r;
  logic [1:0]  tick_r;

  logic [16:0] lam_r;
  logic [30:0] icov_r;
  logic signed [31:0] init_r [PARAM_COUNT];
  logic signed [31:0] th_r [PARAM_COUNT];
  logic signed [31:0] p_r [PARAM_COUNT*PARAM_COUNT];
  logic signed [31:0] u_r [2];
  logic signed [31:0] y_r [2];
  logic signed [31:0] phi_r [PARAM_COUNT];
  logic signed [31:0] pphi_r [PARAM_COUNT];
  logic signed [31:0] phip_r [PARAM_COUNT];
  logic signed [31:0] gain_r [PARAM_COUNT];
  logic signed [31:0] e_r, yin_r, uin_r, den_r;
  logic signed [32:0] pd_r;
  logic signed [31:0] ma, mb;
  logic signed [67:0] acc;
  logic mclr, men, dstart, ddone;
  logic signed [63:0] dnum, dden, dquo;
  logic signed [63:0] lam_f;
  logic [3:0] pidx;
  logic cfg_hit;

  assign pidx = {i_r, j_r};
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == S_IDLE) && !out_valid;
  assign cfg_hit   = cfg_valid && cfg_ready && (cfg_index < 3'(NUM_REGS));

  generate
    if (FRAC_BITS >= 16) begin : g_lup
      assign lam_f = 64'(lam_r) <<< (FRAC_BITS - 16);
    end else begin : g_ldn
      assign lam_f = 64'(lam_r) >>> (16 - FRAC_BITS);
    end
  endgenerate

  // Multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (ph_r)
      PH_E:    begin ma = th_r[j_r]; mb = phi_r[j_r]; end
      PH_PPHI: begin ma = p_r[pidx]; mb = phi_r[j_r]; end
      PH_DEN:  begin ma = phi_r[j_r]; mb = pphi_r[j_r]; end
      PH_PHIP: begin ma = phi_r[j_r]; mb = p_r[{j_r, i_r}]; end
      PH_TH:   begin ma = gain_r[i_r]; mb = e_r; end
      PH_PUPD: begin ma = gain_r[i_r]; mb = phip_r[j_r]; end
      default: ;
    endcase
  end

  assign men  = (state_r == S_MAC);
  assign mclr = (state_r == S_IDLE) || (state_r == S_DWAIT && ddone) ||
                (state_r == S_MWAIT && tick_r == 2'd2);

  rls_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .clr(mclr), .en(men), .a(ma), .b(mb), .acc(acc)
  );

  // Divider operands: gain or covariance rescale
  always_comb begin
    if (ph_r == PH_GAIN) begin
      dnum = 64'(pphi_r[i_r]) <<< FRAC_BITS;
      dden = 64'(den_r);
    end else begin
      dnum = 64'(pd_r) <<< 16;
      dden = 64'(lam_r);
    end
  end

  rls_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(dquo)
  );

  assign dstart = (state_r == S_DIV);

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      lam_r  <= LAMBDA_RST;
      icov_r <= INITCOV_RST;
      ph_r <= PH_E; i_r <= '0; j_r <= '0; tick_r <= '0;
      for (int k = 0; k < PARAM_COUNT; k++) begin
        init_r[k] <= '0;
        th_r[k]   <= '0;
      end
      for (int k = 0; k < PARAM_COUNT*PARAM_COUNT; k++)
        p_r[k] <= (k % 5 == 0) ? {1'b0, INITCOV_RST} : '0;
      u_r[0] <= '0; u_r[1] <= '0; y_r[0] <= '0; y_r[1] <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_hit) begin
            logic [30:0] ic;
            logic signed [31:0] nin [PARAM_COUNT];
            ic = icov_r;
            for (int k = 0; k < PARAM_COUNT; k++) nin[k] = init_r[k];
            unique case (cfg_index)
              REG_LAMBDA:  lam_r <= cfg_data[16:0];
              REG_INITCOV: ic = cfg_data[30:0];
              REG_INIT_A1: nin[0] = cfg_data;
              REG_INIT_A2: nin[1] = cfg_data;
              REG_INIT_B1: nin[2] = cfg_data;
              REG_INIT_B2: nin[3] = cfg_data;
              default: ;
            endcase
            icov_r <= ic;
            for (int k = 0; k < PARAM_COUNT; k++) begin
              init_r[k] <= nin[k];
              th_r[k]   <= nin[k];
            end
            for (int k = 0; k < PARAM_COUNT*PARAM_COUNT; k++)
              p_r[k] <= (k % 5 == 0) ? {1'b0, ic} : '0;
            u_r[0] <= '0; u_r[1] <= '0; y_r[0] <= '0; y_r[1] <= '0;
          end else if (in_valid && !in_stall) begin
            uin_r <= in_data.plant_input;
            yin_r <= in_data.plant_output;
            phi_r[0] <= sat32(-68'(y_r[0]));
            phi_r[1] <= sat32(-68'(y_r[1]));
            phi_r[2] <= u_r[0];
            phi_r[3] <= u_r[1];
            ph_r <= PH_E; i_r <= '0; j_r <= '0;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          // accumulate over j (or single product for TH/PUPD)
          if (ph_r == PH_TH || ph_r == PH_PUPD || j_r == 2'd3) begin
            tick_r <= '0;
            state_r <= S_MWAIT;
          end else begin
            j_r <= j_r + 2'd1;
          end
        end
        S_MWAIT: begin
          tick_r <= tick_r + 2'd1;
          if (tick_r == 2'd2) begin
            unique case (ph_r)
              PH_E: begin
                e_r <= sat32(68'(yin_r) - 68'(sat32(acc)));
                ph_r <= PH_PPHI;
                j_r <= '0;
                state_r <= S_MAC;
              end
              PH_PPHI: begin
                pphi_r[i_r] <= sat32(acc);
                i_r <= i_r + 2'd1;
                if (i_r == 2'd3) ph_r <= PH_DEN;
                j_r <= '0;
                state_r <= S_MAC;
              end
              PH_DEN: begin
                den_r <= sat32(68'(sat32(acc)) + 68'(lam_f));
                ph_r <= PH_PHIP;
                j_r <= '0;
                state_r <= S_MAC;
              end
              PH_PHIP: begin
                phip_r[i_r] <= sat32(acc);
                i_r <= i_r + 2'd1;
                j_r <= '0;
                if (i_r == 2'd3) begin
                  if (den_r == '0) begin
                    // zero denominator: gains are set to zero
                    for (int k = 0; k < PARAM_COUNT; k++) gain_r[k] <= '0;
                    ph_r <= PH_TH;
                    state_r <= S_MAC;
                  end else begin
                    ph_r <= PH_GAIN;
                    state_r <= S_DIV;
                  end
                end else begin
                  state_r <= S_MAC;
                end
              end
              PH_TH: begin
                th_r[i_r] <= sat32(68'(th_r[i_r]) + 68'(sat32(acc)));
                i_r <= i_r + 2'd1;
                if (i_r == 2'd3) ph_r <= PH_PUPD;
                j_r <= '0;
                state_r <= S_MAC;
              end
              PH_PUPD: begin
                // difference kept unsaturated for the lambda rescale
                pd_r <= 33'(p_r[pidx]) - 33'(sat32(acc));
                if (lam_r == '0) begin
                  p_r[pidx] <= sat32(68'(p_r[pidx]) - 68'(sat32(acc)));
                  {i_r, j_r} <= pidx + 4'd1;
                  state_r <= (pidx == 4'd15) ? S_OUT : S_MAC;
                end else begin
                  state_r <= S_DIV;
                end
              end
              default: state_r <= S_MAC;
            endcase
          end
        end
        S_DIV: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (ddone) begin
            if (ph_r == PH_GAIN) begin
              gain_r[i_r] <= sat32(68'(dquo));
              i_r <= i_r + 2'd1;
              if (i_r == 2'd3) begin
                ph_r <= PH_TH; j_r <= '0; state_r <= S_MAC;
              end else state_r <= S_DIV;
            end else begin
              p_r[pidx] <= sat32(68'(dquo));
              {i_r, j_r} <= pidx + 4'd1;
              state_r <= (pidx == 4'd15) ? S_OUT : S_MAC;
            end
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_data.est_a1 <= th_r[0];
            out_data.est_a2 <= th_r[1];
            out_data.est_b1 <= th_r[2];
            out_data.est_b2 <= th_r[3];
            out_data.prediction_error <= e_r;
            out_valid <= 1'b1;
            u_r[1] <= u_r[0]; u_r[0] <= uin_r;
            y_r[1] <= y_r[0]; y_r[0] <= yin_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Assertions
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> (state_r == S_IDLE)) else $error("config while busy");

endmodule

// ===== tb/sv/rls_arx_parameter_estimator_top_checker.sv =====
`timescale 1ns / 100ps
// Checker for the RLS ARX estimator: watches the sample, result and config
// channels, predicts each result and compares it. Depends on rls_pkg.
module rls_arx_parameter_estimator_top_checker import rls_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  rls_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  rls_out_t    out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatch_count,
  output int          results_pending
);

  // Estimator registers and state as the checker sees them
  logic [16:0] lambda_q;
  logic [30:0] init_cov;
  int          init_theta[4];
  int          theta[4];
  int          cov[16];
  int          u_hist[2];
  int          y_hist[2];
  rls_out_t    expected_results[$];

  function automatic int clip(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // Q16.16 product, round half up, floor shift
  function automatic longint qmul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b) + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic void reload_state();
    for (int i = 0; i < 4; i++) theta[i] = init_theta[i];
    for (int i = 0; i < 16; i++) cov[i] = (i % 5 == 0) ? int'({1'b0, init_cov}) : 0;
    u_hist = '{0, 0};
    y_hist = '{0, 0};
  endfunction

  // One RLS update; returns updated theta and the innovation
  function automatic rls_out_t predict_result(rls_in_t s);
    int       phi[4];
    int       pphi[4];
    int       gain[4];
    int       phip[4];
    int       err;
    longint   acc;
    longint   den;
    longint   d;
    rls_out_t r;
    phi[0] = clip(-longint'(y_hist[0]));
    phi[1] = clip(-longint'(y_hist[1]));
    phi[2] = u_hist[0];
    phi[3] = u_hist[1];
    acc = 0;
    for (int i = 0; i < 4; i++) acc += qmul(theta[i], phi[i]);
    err = clip(longint'(s.plant_output) - longint'(clip(acc)));
    for (int i = 0; i < 4; i++) begin
      acc = 0;
      for (int j = 0; j < 4; j++) acc += qmul(cov[i*4+j], phi[j]);
      pphi[i] = clip(acc);
    end
    acc = 0;
    for (int i = 0; i < 4; i++) acc += qmul(phi[i], pphi[i]);
    den = longint'(clip(longint'(clip(acc)) + longint'(lambda_q)));
    for (int i = 0; i < 4; i++)
      gain[i] = (den == 0) ? 0 : clip((longint'(pphi[i]) * 64'sd65536) / den);
    for (int i = 0; i < 4; i++)
      theta[i] = clip(longint'(theta[i]) + longint'(clip(qmul(gain[i], err))));
    for (int j = 0; j < 4; j++) begin
      acc = 0;
      for (int i = 0; i < 4; i++) acc += qmul(phi[i], cov[i*4+j]);
      phip[j] = clip(acc);
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        d = longint'(cov[i*4+j]) - longint'(clip(qmul(gain[i], phip[j])));
        if (lambda_q != 0) d = (d * 64'sd65536) / longint'(lambda_q);
        cov[i*4+j] = clip(d);
      end
    end
    u_hist[1] = u_hist[0];
    u_hist[0] = s.plant_input;
    y_hist[1] = y_hist[0];
    y_hist[0] = s.plant_output;
    r.est_a1 = theta[0];
    r.est_a2 = theta[1];
    r.est_b1 = theta[2];
    r.est_b2 = theta[3];
    r.prediction_error = err;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch %s: got %h expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  initial mismatch_count = 0;

  always @(posedge clk) begin
    rls_out_t want;
    if (!rst_n) begin
      lambda_q = LAMBDA_RST;
      init_cov = INITCOV_RST;
      init_theta = '{0, 0, 0, 0};
      reload_state();
      expected_results.delete();
    end else begin
      // config transaction; unknown indexes leave everything alone
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LAMBDA:  begin lambda_q = cfg_data[16:0]; reload_state(); end
          REG_INITCOV: begin init_cov = cfg_data[30:0]; reload_state(); end
          REG_INIT_A1: begin init_theta[0] = cfg_data; reload_state(); end
          REG_INIT_A2: begin init_theta[1] = cfg_data; reload_state(); end
          REG_INIT_B1: begin init_theta[2] = cfg_data; reload_state(); end
          REG_INIT_B2: begin init_theta[3] = cfg_data; reload_state(); end
          default: ;
        endcase
      end
      // result transaction
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: mismatch: result with none expected", $time);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.est_a1 !== want.est_a1)
            report_mismatch("est_a1", out_data.est_a1, want.est_a1);
          if (out_data.est_a2 !== want.est_a2)
            report_mismatch("est_a2", out_data.est_a2, want.est_a2);
          if (out_data.est_b1 !== want.est_b1)
            report_mismatch("est_b1", out_data.est_b1, want.est_b1);
          if (out_data.est_b2 !== want.est_b2)
            report_mismatch("est_b2", out_data.est_b2, want.est_b2);
          if (out_data.prediction_error !== want.prediction_error)
            report_mismatch("prediction_error", out_data.prediction_error,
                            want.prediction_error);
        end
      end
      // sample transaction
      if (in_valid && !in_stall) expected_results.push_back(predict_result(in_data));
    end
    results_pending = expected_results.size();
  end

endmodule

// ===== tb/sv/rls_arx_parameter_estimator_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the RLS ARX estimator: clock, reset, sample and config
// stimulus, verdict. Depends on rls_pkg and the checker module.
module rls_arx_parameter_estimator_top_tb;
  import rls_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  rls_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rls_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          mismatch_count;
  int          results_pending;
  int          idle_cycles = 0;
  bit          calm = 1'b0;

  always #5 clk = ~clk;

  rls_arx_parameter_estimator_top i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  rls_arx_parameter_estimator_top_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatch_count, .results_pending
  );

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side back-pressure
  initial begin
    forever begin
      @(negedge clk);
      if (!calm) begin
        out_stall = 1'b1;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h4ffff) - 32'h28000;
    endcase
  endfunction

  task automatic send_sample(logic [31:0] u, logic [31:0] y);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.plant_input = u;
    in_data.plant_output = y;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_samples(int n);
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      send_sample(rand_word(), rand_word());
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset settings with field extremes
    send_sample(32'h7fffffff, 32'h80000000);
    send_sample(32'h80000000, 32'h7fffffff);
    send_sample(32'h0, 32'h0);
    send_sample(32'hffffffff, 32'hffffffff);
    send_sample(32'h00010000, 32'h00008000);
    send_sample(32'h80000000, 32'h80000000);
    send_sample(32'h7fffffff, 32'h7fffffff);
    drain();

    // Zero lambda and zero covariance: zero denominator, no rescale
    write_reg(REG_LAMBDA, 32'd0);
    write_reg(REG_INITCOV, 32'd0);
    write_reg(REG_INIT_A1, 32'h00010000);
    for (int k = 0; k < 5; k++) send_sample(rand_word(), rand_word());
    drain();

    // Out-of-range indexes must not reinitialize
    write_reg(3'd6, 32'hffffffff);
    write_reg(3'd7, 32'h12345678);
    send_sample(32'h00020000, 32'hfffe0000);
    send_sample(32'h00030000, 32'h00050000);
    drain();

    // Top extremes of lambda and covariance, signed extremes of the init registers
    write_reg(REG_LAMBDA, 32'h0001ffff);
    write_reg(REG_INITCOV, 32'h7fffffff);
    write_reg(REG_INIT_A1, 32'h7fffffff);
    write_reg(REG_INIT_A2, 32'h80000000);
    write_reg(REG_INIT_B1, 32'h7fffffff);
    write_reg(REG_INIT_B2, 32'h80000000);
    for (int k = 0; k < 6; k++) send_sample(rand_word(), rand_word());
    drain();

    // Low extremes
    write_reg(REG_LAMBDA, 32'd1);
    write_reg(REG_INITCOV, 32'd1);
    write_reg(REG_INIT_A2, 32'h0);
    random_samples(40);
    drain();

    // Random settings; mostly usable lambda, sometimes any 17-bit value
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(REG_LAMBDA, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071)
                                                         : $urandom_range(58982, 65536));
      write_reg(REG_INITCOV, ($urandom_range(0, 2) == 0) ? $urandom
                                                         : $urandom_range(1, 32'h0fffffff));
      write_reg(REG_INIT_A1, rand_word());
      write_reg(REG_INIT_A2, rand_word());
      write_reg(REG_INIT_B1, rand_word());
      write_reg(REG_INIT_B2, rand_word());
      random_samples(125);
      drain();
    end

    // Back to the nominal setting
    write_reg(REG_LAMBDA, 32'd64881);
    write_reg(REG_INITCOV, 32'd65536000);
    random_samples(50);
    drain();

    repeat (1200) @(negedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rls_pkg.sv
rtl/rls_mac.sv
rtl/rls_div.sv
rtl/rls_arx_parameter_estimator_top.sv
tb/sv/rls_arx_parameter_estimator_top_checker.sv
tb/sv/rls_arx_parameter_estimator_top_tb.sv
